FILE: sv/fbpa_pkg.sv
// fbpa_pkg: shared types and constants for the fixed block pool allocator
// no dependencies; imported by every module of the allocator

package fbpa_pkg;

    localparam int POOL_BLOCKS = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 16;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(POOL_BLOCKS);

    typedef enum logic [0:0] {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_FREE     = 2'd1,
        ST_NOT_IN_POOL = 2'd2
    } status_t;

    // classified request as held in the queue
    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] block_index;
        logic             in_pool;
    } cmd_t;

    typedef struct packed {
        logic             event_res;
        logic [CNT_W-1:0] free_count;
        logic [IDX_W-1:0] granted_index;
        status_t          status;
    } result_t;

endpackage

FILE: sv/fbpa_front.sv
// fbpa_front: accepts requests and classifies them against the pool limit
// depends on fbpa_pkg

module fbpa_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fbpa_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic [fbpa_pkg::CNT_W-1:0]   limit,
    output logic                         push,
    output fbpa_pkg::cmd_t               push_cmd,
    input  logic                         q_full
);
    import fbpa_pkg::*;

    logic [IDX_W-1:0] idx;

    always_comb begin
        idx                  = s_tdata[IDX_W-1:0];
        s_tready             = !q_full;
        push                 = s_tvalid && !q_full;
        push_cmd.kind        = kind_t'(s_tuser);
        push_cmd.block_index = idx;
        push_cmd.in_pool     = {1'b0, idx} < limit;
    end

endmodule

FILE: sv/fbpa_queue.sv
// fbpa_queue: short fifo of classified requests between front and back
// depends on fbpa_pkg

module fbpa_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fbpa_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output fbpa_pkg::cmd_t pop_cmd,
    output logic           valid
);
    import fbpa_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        full        = count_reg == Q_CNT_W'(Q_DEPTH);
        valid       = count_reg != '0;
        pop_cmd     = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    a_q_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue pushed while full");
    a_q_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid |-> !pop)
        else $error("queue popped while empty");
    a_q_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

FILE: sv/fbpa_back.sv
// fbpa_back: block flags, first-fit search, free count and result register
// depends on fbpa_pkg

module fbpa_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  fbpa_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    input  logic [fbpa_pkg::CNT_W-1:0]    limit,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fbpa_pkg::M_DATA_W-1:0] m_tdata
);
    import fbpa_pkg::*;

    logic [POOL_BLOCKS-1:0] used_flags_reg, used_flags_next;
    logic [CNT_W-1:0]       used_count_reg, used_count_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic [POOL_BLOCKS-1:0] limit_mask;
    logic [POOL_BLOCKS-1:0] avail;
    logic                   found;
    logic [IDX_W-1:0]       first;
    logic                   take;

    always_comb begin
        take  = !out_valid_reg || m_tready;
        q_pop = q_valid && take;

        for (int i = 0; i < POOL_BLOCKS; i++) begin
            limit_mask[i] = CNT_W'(i) < limit;
        end
        avail = ~used_flags_reg & limit_mask;

        // lowest free block
        found = 1'b0;
        first = '0;
        for (int i = POOL_BLOCKS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                found = 1'b1;
                first = IDX_W'(i);
            end
        end

        used_flags_next       = used_flags_reg;
        used_count_next       = used_count_reg;
        out_next              = out_reg;
        out_next.status       = ST_OK;
        out_next.granted_index = '0;
        out_next.event_res    = 1'b0;

        if (q_cmd.kind == KIND_ALLOC) begin
            if (found) begin
                used_flags_next[first] = 1'b1;
                used_count_next        = used_count_reg + CNT_W'(1);
                out_next.granted_index = first;
                out_next.event_res     = 1'b1;
            end else begin
                out_next.status = ST_NO_FREE;
            end
        end else begin
            if (q_cmd.in_pool) begin
                if (used_flags_reg[q_cmd.block_index]) begin
                    used_flags_next[q_cmd.block_index] = 1'b0;
                    used_count_next                    = used_count_reg - CNT_W'(1);
                end
                out_next.event_res = 1'b1;
            end else begin
                out_next.status = ST_NOT_IN_POOL;
            end
        end

        out_next.free_count = (limit > used_count_next) ? limit - used_count_next : '0;

        if (!q_pop) begin
            used_flags_next = used_flags_reg;
            used_count_next = used_count_reg;
            out_next        = out_reg;
        end

        out_valid_next = q_pop ? 1'b1 : (out_valid_reg && !m_tready);

        m_tvalid = out_valid_reg;
        m_tdata  = out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_flags_reg <= '0;
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            used_flags_reg <= used_flags_next;
            used_count_reg <= used_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

`ifndef SYNTH
    a_count_matches_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg == CNT_W'($countones(used_flags_reg)))
        else $error("used count out of step with block flags");
    a_event_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.event_res |-> out_reg.status == ST_OK)
        else $error("event on failed request");
    a_grant_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_cmd.kind == KIND_ALLOC && found |=> used_flags_reg[out_reg.granted_index])
        else $error("granted block not marked used");
`endif

endmodule

FILE: sv/fixed_block_pool_allocator_core.sv
// fixed_block_pool_allocator_core: top level of the first-fit block pool allocator
// depends on fbpa_pkg, fbpa_front, fbpa_queue, fbpa_back
//
//  channel   ports            carries
//  -------   --------------   ------------------------------------------------
//  request   s_tvalid/tready  tuser kind, tdata block index
//  result    m_tvalid/tready  tdata status, granted index, free count, event
//  config    cfg_wr_en        cfg_wr_data blocks in use, applied at once
//
//  one request a cycle sustained while the result side does not stall; an accepted
//  request is written into the queue, and the result register loads from the queue
//  head when the result side can take it; the first-fit search over the 64 block
//  flags is combinational in the back end
//  synchronous active-low reset frees every block and sets blocks in use to 64
//  a stalled result holds the back end; the two-entry queue then fills and
//  drops s_tready

module fixed_block_pool_allocator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fbpa_pkg::S_DATA_W-1:0] s_tdata,   // [5:0] block_index, [7:6] zero
    input  logic                          s_tuser,   // [0] kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fbpa_pkg::M_DATA_W-1:0] m_tdata,   // [1:0] status, [7:2] granted_index,
                                                     // [14:8] free_count, [15] event_res
    input  logic                          cfg_wr_en,
    input  logic [fbpa_pkg::CNT_W-1:0]    cfg_wr_data
);
    import fbpa_pkg::*;

    logic [CNT_W-1:0] blocks_in_use_reg, blocks_in_use_next;
    logic [CNT_W-1:0] limit;
    logic             push, q_full, q_valid, q_pop;
    cmd_t             push_cmd, q_cmd;

    always_comb begin
        blocks_in_use_next = cfg_wr_en ? cfg_wr_data : blocks_in_use_reg;
        limit = (blocks_in_use_reg > CNT_W'(POOL_BLOCKS)) ? CNT_W'(POOL_BLOCKS)
                                                          : blocks_in_use_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_in_use_reg <= LIMIT_RESET;
        end else begin
            blocks_in_use_reg <= blocks_in_use_next;
        end
    end

    fbpa_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .limit    (limit),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    fbpa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .valid    (q_valid)
    );

    fbpa_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .limit    (limit),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: bench/tb_fixed_block_pool_allocator_core.sv
// tb_fixed_block_pool_allocator_core: self-checking bench for the first-fit block pool allocator
// depends on fbpa_pkg and fixed_block_pool_allocator_core; keeps its own copy of the pool flags
// and predicts every result, then drives directed, back-pressure and random request traffic

module tb_fixed_block_pool_allocator_core;
    import fbpa_pkg::*;

    localparam int MAX_GAP = 18;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wr_en;
    logic [CNT_W-1:0]    cfg_wr_data;

    // predicted pool state
    logic [POOL_BLOCKS-1:0] pool_flags;
    int unsigned            pool_used;
    logic [CNT_W-1:0]       pool_limit;
    result_t                pending_results[$];

    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned allocs_sent;
    int unsigned grants_predicted;
    int unsigned exhausted_predicted;
    int unsigned outside_predicted;
    int unsigned limits_written;
    bit          send_gaps;
    bit          recv_stalls;
    int unsigned recv_hold;

    fixed_block_pool_allocator_core DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("timeout at %0t with %0d results outstanding", $time, pending_results.size());
        $display("simulation failed");
        $finish;
    end

    function automatic result_t predict_request(kind_t kind, logic [IDX_W-1:0] idx);
        result_t     r;
        int unsigned lim;
        bit          found;
        lim = (pool_limit > POOL_BLOCKS) ? POOL_BLOCKS : pool_limit;
        found = 1'b0;
        r.status        = ST_OK;
        r.granted_index = '0;
        r.event_res     = 1'b0;
        if (kind == KIND_ALLOC) begin
            r.status = ST_NO_FREE;
            for (int i = 0; i < lim; i++) begin
                if (!found && !pool_flags[i]) begin
                    found           = 1'b1;
                    pool_flags[i]   = 1'b1;
                    pool_used++;
                    r.granted_index = IDX_W'(i);
                    r.status        = ST_OK;
                    r.event_res     = 1'b1;
                end
            end
        end else if (idx < lim) begin
            // freeing an already free block succeeds without touching the count
            if (pool_flags[idx]) begin
                pool_flags[idx] = 1'b0;
                if (pool_used > 0)
                    pool_used--;
            end
            r.event_res = 1'b1;
        end else begin
            r.status = ST_NOT_IN_POOL;
        end
        r.free_count = (lim > pool_used) ? CNT_W'(lim - pool_used) : '0;
        return r;
    endfunction

    task automatic send_request(kind_t kind, logic [IDX_W-1:0] idx);
        int unsigned gap;
        result_t     r;
        gap = send_gaps ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, idx};
        do @(posedge aclk); while (!s_tready);
        r = predict_request(kind, idx);
        pending_results.push_back(r);
        requests_sent++;
        if (kind == KIND_ALLOC)
            allocs_sent++;
        if (r.status == ST_OK && kind == KIND_ALLOC)
            grants_predicted++;
        if (r.status == ST_NO_FREE)
            exhausted_predicted++;
        if (r.status == ST_NOT_IN_POOL)
            outside_predicted++;
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        pool_limit  = value;
        limits_written++;
    endtask

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result side: random stalls, long hold-off on request, compare in order
    initial begin : result_checker
        result_t     got;
        result_t     want;
        int unsigned stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    report_field("status", want.status, got.status);
                    report_field("granted_index", want.granted_index, got.granted_index);
                    report_field("free_count", want.free_count, got.free_count);
                    report_field("event_res", want.event_res, got.event_res);
                end
                stall = recv_stalls ? $urandom_range(MAX_GAP, 0) : 0;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    task automatic test_directed_requests();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_ALLOC, 6'd63);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_FREE, 6'd1);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_FREE, 6'd63);
        send_request(KIND_FREE, 6'd1);
        send_request(KIND_FREE, 6'd1);
        wait_until_drained();
    endtask

    task automatic test_limit_edges();
        // limit below the blocks in use: free count saturates, upper blocks locked
        write_limit(7'd1);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_FREE, 6'd2);
        send_request(KIND_FREE, 6'd0);
        send_request(KIND_ALLOC, 6'd0);
        wait_until_drained();
        write_limit(7'd0);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_FREE, 6'd0);
        wait_until_drained();
        // oversize limit acts as the full pool
        write_limit(7'd127);
        send_request(KIND_FREE, 6'd63);
        send_request(KIND_ALLOC, 6'd0);
        send_request(KIND_FREE, 6'd2);
        send_request(KIND_FREE, 6'd0);
        send_request(KIND_FREE, 6'd1);
        wait_until_drained();
        write_limit(LIMIT_RESET);
    endtask

    task automatic test_backpressure();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        recv_hold   = 300;
        for (int i = 0; i < 24; i++)
            send_request(kind_t'(i % 3 == 2), IDX_W'($urandom_range(63, 0)));
        wait_until_drained();
    endtask

    task automatic test_random_traffic();
        logic [CNT_W-1:0] fixed_limits[8];
        logic [IDX_W-1:0] candidates[$];
        logic [CNT_W-1:0] lim_value;
        int unsigned      alloc_pct;
        int unsigned      lim;
        kind_t            kind;
        logic [IDX_W-1:0] idx;
        fixed_limits = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63, 7'd33};
        for (int p = 0; p < 12; p++) begin
            wait_until_drained();
            lim_value = (p < 8) ? fixed_limits[p] : CNT_W'($urandom_range(127, 0));
            write_limit(lim_value);
            send_gaps   = (p % 4) != 0;
            recv_stalls = (p % 4) > 1 || (p % 4) == 0 && p > 6;
            lim = (pool_limit > POOL_BLOCKS) ? POOL_BLOCKS : pool_limit;
            alloc_pct = $urandom_range(85, 25);
            for (int n = 0; n < 125; n++) begin
                // swing between filling and emptying the pool
                if (n % 40 == 39)
                    alloc_pct = $urandom_range(90, 15);
                if ($urandom_range(99, 0) < alloc_pct) begin
                    kind = KIND_ALLOC;
                    idx  = IDX_W'($urandom_range(63, 0));
                end else begin
                    kind = KIND_FREE;
                    candidates.delete();
                    for (int b = 0; b < lim; b++)
                        if (pool_flags[b])
                            candidates.push_back(IDX_W'(b));
                    if (candidates.size() != 0 && $urandom_range(99, 0) < 70)
                        idx = candidates[$urandom_range(candidates.size() - 1, 0)];
                    else
                        idx = IDX_W'($urandom_range(63, 0));
                end
                send_request(kind, idx);
            end
        end
        wait_until_drained();
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        pool_flags  = '0;
        pool_used   = 0;
        pool_limit  = LIMIT_RESET;
        mismatches  = 0;
        requests_sent = 0;
        allocs_sent = 0;
        grants_predicted = 0;
        exhausted_predicted = 0;
        outside_predicted = 0;
        limits_written = 0;
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        recv_hold   = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_requests();
        test_limit_edges();
        test_backpressure();
        test_random_traffic();

        repeat (10) @(posedge aclk);
        $display("%0d requests (%0d allocate), %0d grants, %0d pool exhausted, %0d out of pool",
                 requests_sent, allocs_sent, grants_predicted, exhausted_predicted,
                 outside_predicted);
        $display("%0d limit writes incl. zero, one, full and oversize; %0d mismatches",
                 limits_written, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
